/* sv/pbcf_pkg.sv */
// Shared types, codes and saturation helpers for the plane border collision block.
package pbcf_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND     = 3'd0,
        CFG_NORMAL_X = 3'd1,
        CFG_NORMAL_Y = 3'd2,
        CFG_CORNER_X = 3'd3,
        CFG_CORNER_Y = 3'd4,
        CFG_DT       = 3'd5,
        CFG_FRICTION = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_STICKY   = 2'd0,
        BK_SEPARATE = 2'd1,
        BK_SLIP     = 2'd2,
        BK_NONE     = 2'd3
    } border_kind_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [19:0] node_index;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               collided;
        logic        [19:0] node_id_out;
    } out_item_t;

    // sideband through the d / dt divider
    typedef struct packed {
        in_item_t           item;
        logic               d_pos;
        logic               d_neg;
        logic signed [34:0] nv_hi;
    } dt_sb_t;

    // sideband through the two norm square-root units
    typedef struct packed {
        logic signed [31:0] vc;
        logic signed [31:0] tan;
        logic               hit;
    } sqa_sb_t;

    typedef struct packed {
        logic signed [31:0] vc;
        logic signed [31:0] tan;
        logic        [19:0] node;
    } sqb_sb_t;

    // sideband through the two friction dividers
    typedef struct packed {
        logic signed [31:0] vc;
        logic               neg;
        logic               nt_nz;
    } fda_sb_t;

    typedef struct packed {
        logic signed [31:0] vc;
        logic               neg;
        logic               hit;
        logic        [19:0] node;
    } fdb_sb_t;

    localparam logic signed [63:0] SAT_HI  = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO  = -64'sd2147483648;
    localparam logic signed [63:0] TAN_LO  = -64'sd2147483647;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
        return r[31:0];
    endfunction

    // symmetric clamp to +-(2^31 - 1)
    function automatic logic signed [31:0] tclamp(input logic signed [63:0] x);
        logic signed [63:0] r;
        r = (x > SAT_HI) ? SAT_HI : ((x < TAN_LO) ? TAN_LO : x);
        return r[31:0];
    endfunction

endpackage

/* sv/pbcf_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
module pbcf_div #(
    parameter int DVD_W = 64,
    parameter int DVS_W = 32,
    parameter int QUO_W = 32,
    parameter int SB_W  = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_vld,
    output logic [QUO_W-1:0] quotient,
    output logic [SB_W-1:0]  sb_out
);
    // quotient must fit in QUO_W bits: dividend >> QUO_W is below the divisor

    logic [DVS_W+DVD_W-1:0] dvd_ext;
    assign dvd_ext = {{DVS_W{1'b0}}, dividend};

    logic [DVS_W-1:0] rem_reg  [QUO_W];
    logic [DVS_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] lo_reg   [QUO_W];
    logic [QUO_W-1:0] lo_next  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];
    logic [DVS_W-1:0] dvs_reg  [QUO_W];
    logic [SB_W-1:0]  sb_reg   [QUO_W];
    logic             vld_reg  [QUO_W];

    genvar i;
    for (i = 0; i < QUO_W; i++) begin : g_stage
        logic [DVS_W-1:0] rem_src;
        logic [QUO_W-1:0] lo_src;
        logic [QUO_W-1:0] quo_src;
        logic [DVS_W-1:0] dvs_src;
        logic [SB_W-1:0]  sb_src;
        logic             vld_src;
        logic [DVS_W:0]   rem_sh;
        logic [DVS_W:0]   rem_sub;
        logic             take;

        if (i == 0) begin : g_first
            assign rem_src = dvd_ext[QUO_W +: DVS_W];
            assign lo_src  = dvd_ext[QUO_W-1:0];
            assign quo_src = '0;
            assign dvs_src = divisor;
            assign sb_src  = sb_in;
            assign vld_src = in_vld;
        end else begin : g_rest
            assign rem_src = rem_reg[i-1];
            assign lo_src  = lo_reg[i-1];
            assign quo_src = quo_reg[i-1];
            assign dvs_src = dvs_reg[i-1];
            assign sb_src  = sb_reg[i-1];
            assign vld_src = vld_reg[i-1];
        end

        assign rem_sh      = {rem_src, lo_src[QUO_W-1]};
        assign rem_sub     = rem_sh - {1'b0, dvs_src};
        assign take        = (rem_sh >= {1'b0, dvs_src});
        assign rem_next[i] = take ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        assign lo_next[i]  = lo_src << 1;
        assign quo_next[i] = QUO_W'({quo_src, take});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next[i];
                lo_reg[i]  <= lo_next[i];
                quo_reg[i] <= quo_next[i];
                dvs_reg[i] <= dvs_src;
                sb_reg[i]  <= sb_src;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign quotient = quo_reg[QUO_W-1];
    assign sb_out   = sb_reg[QUO_W-1];

endmodule

/* sv/pbcf_sqrt.sv */
// Pipelined floor square root, one root bit per stage.
module pbcf_sqrt #(
    parameter int RT_W = 32,
    parameter int SB_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2*RT_W-1:0] radicand,
    input  logic [SB_W-1:0]   sb_in,
    output logic              out_vld,
    output logic [RT_W-1:0]   root,
    output logic [SB_W-1:0]   sb_out
);
    localparam int IN_W = 2 * RT_W;

    logic [RT_W+1:0] rem_reg   [RT_W];
    logic [RT_W+1:0] rem_next  [RT_W];
    logic [IN_W-1:0] x_reg     [RT_W];
    logic [IN_W-1:0] x_next    [RT_W];
    logic [RT_W-1:0] root_reg  [RT_W];
    logic [RT_W-1:0] root_next [RT_W];
    logic [SB_W-1:0] sb_reg    [RT_W];
    logic            vld_reg   [RT_W];

    genvar i;
    for (i = 0; i < RT_W; i++) begin : g_stage
        logic [RT_W+1:0] rem_src;
        logic [IN_W-1:0] x_src;
        logic [RT_W-1:0] root_src;
        logic [SB_W-1:0] sb_src;
        logic            vld_src;
        logic [RT_W+3:0] rem_sh;
        logic [RT_W+3:0] trial;
        logic [RT_W+3:0] rem_sub;
        logic            take;

        if (i == 0) begin : g_first
            assign rem_src  = '0;
            assign x_src    = radicand;
            assign root_src = '0;
            assign sb_src   = sb_in;
            assign vld_src  = in_vld;
        end else begin : g_rest
            assign rem_src  = rem_reg[i-1];
            assign x_src    = x_reg[i-1];
            assign root_src = root_reg[i-1];
            assign sb_src   = sb_reg[i-1];
            assign vld_src  = vld_reg[i-1];
        end

        assign rem_sh       = {rem_src, x_src[IN_W-1 -: 2]};
        assign trial        = {2'b00, root_src, 2'b01};
        assign rem_sub      = rem_sh - trial;
        assign take         = (rem_sh >= trial);
        assign rem_next[i]  = take ? rem_sub[RT_W+1:0] : rem_sh[RT_W+1:0];
        assign x_next[i]    = x_src << 2;
        assign root_next[i] = RT_W'({root_src, take});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next[i];
                x_reg[i]    <= x_next[i];
                root_reg[i] <= root_next[i];
                sb_reg[i]   <= sb_src;
            end
        end
    end

    assign out_vld = vld_reg[RT_W-1];
    assign root    = root_reg[RT_W-1];
    assign sb_out  = sb_reg[RT_W-1];

endmodule

/* sv/plane_boundary_collision_friction.sv */
// Top level: planar border condition with Coulomb friction for one grid node.
//
// Usage: one grid node transaction enters on s_valid/s_ready (s_data), one
// result transaction leaves on m_valid/m_ready (m_data), in order.
// Border setup goes through cfg_wr_en/cfg_wr_index/cfg_wr_data, one register
// per cycle; write only while the pipeline is empty.
// Throughput: one node per cycle, sustained while the output can drain.
// Pipeline: the 50-stage d/dt divider, the 32-stage norm square roots and the
// 32-stage friction dividers, plus 17 arithmetic and output stages.
// Stall: a single pipeline enable; when the output register holds a result
// and m_ready is low, every stage holds and s_ready drops. Nothing is lost or
// repeated, and s_ready stays high while the output can drain.
// Reset (aresetn low, synchronous): all valid bits clear, border registers go
// to inactive kind, normal (0, 1.0), corner 0, dt 66, friction 0.
module plane_boundary_collision_friction (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  pbcf_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output pbcf_pkg::out_item_t                  m_data,
    input  logic                                 cfg_wr_en,
    input  logic [pbcf_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [pbcf_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
    import pbcf_pkg::*;

    // ---------------------------------------------------------------
    // Border configuration registers
    // ---------------------------------------------------------------
    border_kind_t       kind_reg;
    logic signed [17:0] nx_reg;
    logic signed [17:0] ny_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic        [30:0] dt_reg;
    logic        [17:0] fc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= BK_NONE;
            nx_reg   <= 18'sd0;
            ny_reg   <= 18'sd65536;
            cx_reg   <= 32'sd0;
            cy_reg   <= 32'sd0;
            dt_reg   <= 31'd66;
            fc_reg   <= 18'd0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_index))
                CFG_KIND:     kind_reg <= border_kind_t'(cfg_wr_data[1:0]);
                CFG_NORMAL_X: nx_reg   <= $signed(cfg_wr_data[17:0]);
                CFG_NORMAL_Y: ny_reg   <= $signed(cfg_wr_data[17:0]);
                CFG_CORNER_X: cx_reg   <= $signed(cfg_wr_data);
                CFG_CORNER_Y: cy_reg   <= $signed(cfg_wr_data);
                CFG_DT:       dt_reg   <= cfg_wr_data[30:0];
                CFG_FRICTION: fc_reg   <= cfg_wr_data[17:0];
                default: ;
            endcase
        end
    end

    // zero time step behaves as one
    logic [30:0] dt_eff;
    assign dt_eff = (dt_reg == 31'd0) ? 31'd1 : dt_reg;

    // ---------------------------------------------------------------
    // Global pipeline enable
    // ---------------------------------------------------------------
    logic      m_valid_reg;
    out_item_t m_data_reg;
    logic      adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // S1..S3: signed distance d = n.(p - c) and nv = n.v
    // ---------------------------------------------------------------
    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg;
    in_item_t           s1_item_reg, s2_item_reg, s3_item_reg;
    logic signed [32:0] s1_dpx_reg, s1_dpy_reg;
    logic signed [50:0] s2_pdx_reg, s2_pdy_reg;
    logic signed [49:0] s2_pvx_reg, s2_pvy_reg;
    logic signed [51:0] s3_d_reg;
    logic signed [50:0] s3_nv_reg;

    logic signed [32:0] s1_dpx_next, s1_dpy_next;
    logic signed [50:0] s2_pdx_next, s2_pdy_next;
    logic signed [49:0] s2_pvx_next, s2_pvy_next;
    logic signed [51:0] s3_d_next;
    logic signed [50:0] s3_nv_next;

    always_comb begin
        s1_dpx_next = 33'(s_data.pos_x) - 33'(cx_reg);
        s1_dpy_next = 33'(s_data.pos_y) - 33'(cy_reg);
        s2_pdx_next = nx_reg * s1_dpx_reg;
        s2_pdy_next = ny_reg * s1_dpy_reg;
        s2_pvx_next = nx_reg * s1_item_reg.vel_x;
        s2_pvy_next = ny_reg * s1_item_reg.vel_y;
        s3_d_next   = 52'(s2_pdx_reg) + 52'(s2_pdy_reg);
        s3_nv_next  = 51'(s2_pvx_reg) + 51'(s2_pvy_reg);
    end

    // d / dt for the separating border, only for d > 0
    dt_sb_t             dt_sb_in, dt_sb_out;
    logic               dt_vld_out;
    logic        [49:0] dt_quo;
    logic        [49:0] dt_dvd;
    logic signed [50:0] nv_sh;

    always_comb begin
        nv_sh           = s3_nv_reg >>> 16;
        dt_sb_in.item   = s3_item_reg;
        dt_sb_in.d_pos  = (s3_d_reg > 52'sd0);
        dt_sb_in.d_neg  = s3_d_reg[51];
        dt_sb_in.nv_hi  = nv_sh[34:0];
        dt_dvd          = dt_sb_in.d_pos ? s3_d_reg[49:0] : 50'd0;
    end

    pbcf_div #(
        .DVD_W (50),
        .DVS_W (31),
        .QUO_W (50),
        .SB_W  ($bits(dt_sb_t))
    ) u_dt_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s3_vld_reg),
        .dividend (dt_dvd),
        .divisor  (dt_eff),
        .sb_in    (dt_sb_in),
        .out_vld  (dt_vld_out),
        .quotient (dt_quo),
        .sb_out   (dt_sb_out)
    );

    // ---------------------------------------------------------------
    // S4..S6: correction term and corrected velocity vc
    // ---------------------------------------------------------------
    logic               s4_vld_reg, s5_vld_reg, s6_vld_reg;
    in_item_t           s4_item_reg, s5_item_reg, s6_item_reg;
    logic signed [52:0] s4_corr_reg;
    logic               s4_zero_reg, s4_fix_reg, s5_zero_reg, s5_fix_reg;
    logic signed [44:0] s5_pxh_reg, s5_pxl_reg, s5_pyh_reg, s5_pyl_reg;
    logic signed [31:0] s6_vcx_reg, s6_vcy_reg;
    logic               s6_hit_reg;

    logic signed [52:0] s4_corr_next;
    logic               s4_zero_next, s4_fix_next;
    logic signed [26:0] corr_hi, corr_lo;
    logic signed [44:0] s5_pxh_next, s5_pxl_next, s5_pyh_next, s5_pyl_next;
    logic signed [55:0] shx, shy;
    logic signed [56:0] vrx, vry;
    logic signed [31:0] s6_vcx_next, s6_vcy_next;

    always_comb begin
        s4_corr_next = 53'(dt_sb_out.nv_hi)
                     + (dt_sb_out.d_pos ? $signed({3'b000, dt_quo}) : 53'sd0);
        s4_zero_next = (kind_reg == BK_STICKY) && dt_sb_out.d_neg;
        s4_fix_next  = ((kind_reg == BK_SEPARATE) && s4_corr_next[52])
                     || ((kind_reg == BK_SLIP) && dt_sb_out.d_neg);

        // n * corr split as corr = hi * 2^26 + lo, lo unsigned
        corr_hi     = $signed(s4_corr_reg[52:26]);
        corr_lo     = $signed({1'b0, s4_corr_reg[25:0]});
        s5_pxh_next = nx_reg * corr_hi;
        s5_pxl_next = nx_reg * corr_lo;
        s5_pyh_next = ny_reg * corr_hi;
        s5_pyl_next = ny_reg * corr_lo;

        shx = (56'(s5_pxh_reg) <<< 10) + 56'(s5_pxl_reg >>> 16);
        shy = (56'(s5_pyh_reg) <<< 10) + 56'(s5_pyl_reg >>> 16);
        vrx = 57'(s5_item_reg.vel_x) - 57'(shx);
        vry = 57'(s5_item_reg.vel_y) - 57'(shy);
        if (s5_zero_reg) begin
            s6_vcx_next = 32'sd0;
            s6_vcy_next = 32'sd0;
        end else if (s5_fix_reg) begin
            s6_vcx_next = sat32(64'(vrx));
            s6_vcy_next = sat32(64'(vry));
        end else begin
            s6_vcx_next = s5_item_reg.vel_x;
            s6_vcy_next = s5_item_reg.vel_y;
        end
    end

    // ---------------------------------------------------------------
    // S7..S12: tangential part vt, velocity change dv, squared norms
    // ---------------------------------------------------------------
    logic               s7_vld_reg, s8_vld_reg, s9_vld_reg;
    logic               s10_vld_reg, s11_vld_reg, s12_vld_reg;
    logic signed [31:0] s7_vcx_reg, s7_vcy_reg, s8_vcx_reg, s8_vcy_reg;
    logic signed [31:0] s9_vcx_reg, s9_vcy_reg, s10_vcx_reg, s10_vcy_reg;
    logic signed [31:0] s11_vcx_reg, s11_vcy_reg, s12_vcx_reg, s12_vcy_reg;
    logic               s7_hit_reg, s8_hit_reg, s9_hit_reg;
    logic               s10_hit_reg, s11_hit_reg, s12_hit_reg;
    logic        [19:0] s7_node_reg, s8_node_reg, s9_node_reg;
    logic        [19:0] s10_node_reg, s11_node_reg, s12_node_reg;
    logic signed [49:0] s7_mx_reg, s7_my_reg;
    logic signed [31:0] s7_dx_reg, s7_dy_reg, s8_dx_reg, s8_dy_reg;
    logic signed [31:0] s9_dx_reg, s9_dy_reg, s10_dx_reg, s10_dy_reg;
    logic signed [34:0] s8_nq_reg;
    logic signed [52:0] s9_qx_reg, s9_qy_reg;
    logic signed [31:0] s10_tx_reg, s10_ty_reg, s11_tx_reg, s11_ty_reg;
    logic signed [31:0] s12_tx_reg, s12_ty_reg;
    logic        [61:0] s11_stx_reg, s11_sty_reg, s11_sdx_reg, s11_sdy_reg;
    logic        [63:0] s12_st_reg, s12_sd_reg;

    logic signed [49:0] s7_mx_next, s7_my_next;
    logic signed [32:0] dvx, dvy;
    logic signed [50:0] s8_sum;
    logic signed [50:0] s8_sum_sh;
    logic signed [52:0] s9_qx_next, s9_qy_next;
    logic signed [52:0] qsx, qsy;
    logic signed [53:0] trx, try_v;
    logic signed [63:0] sq_tx, sq_ty, sq_dx, sq_dy;

    always_comb begin
        s7_mx_next = nx_reg * s6_vcx_reg;
        s7_my_next = ny_reg * s6_vcy_reg;
        dvx        = 33'(s6_vcx_reg) - 33'(s6_item_reg.vel_x);
        dvy        = 33'(s6_vcy_reg) - 33'(s6_item_reg.vel_y);

        s8_sum     = 51'(s7_mx_reg) + 51'(s7_my_reg);
        s8_sum_sh  = s8_sum >>> 16;

        s9_qx_next = nx_reg * s8_nq_reg;
        s9_qy_next = ny_reg * s8_nq_reg;

        qsx   = s9_qx_reg >>> 16;
        qsy   = s9_qy_reg >>> 16;
        trx   = 54'(s9_vcx_reg) - 54'(qsx);
        try_v = 54'(s9_vcy_reg) - 54'(qsy);

        sq_tx = 64'(s10_tx_reg) * 64'(s10_tx_reg);
        sq_ty = 64'(s10_ty_reg) * 64'(s10_ty_reg);
        sq_dx = 64'(s10_dx_reg) * 64'(s10_dx_reg);
        sq_dy = 64'(s10_dy_reg) * 64'(s10_dy_reg);
    end

    // norms |vt| and |dv|; the two units run in lockstep
    sqa_sb_t     sqa_in, sqa_out;
    sqb_sb_t     sqb_in, sqb_out;
    logic        sqa_vld, sqb_vld;
    logic [31:0] nt_root, nd_root;

    always_comb begin
        sqa_in.vc  = s12_vcx_reg;
        sqa_in.tan = s12_tx_reg;
        sqa_in.hit = s12_hit_reg;
        sqb_in.vc  = s12_vcy_reg;
        sqb_in.tan = s12_ty_reg;
        sqb_in.node = s12_node_reg;
    end

    pbcf_sqrt #(
        .RT_W (32),
        .SB_W ($bits(sqa_sb_t))
    ) u_sqrt_t (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s12_vld_reg),
        .radicand (s12_st_reg),
        .sb_in    (sqa_in),
        .out_vld  (sqa_vld),
        .root     (nt_root),
        .sb_out   (sqa_out)
    );

    pbcf_sqrt #(
        .RT_W (32),
        .SB_W ($bits(sqb_sb_t))
    ) u_sqrt_d (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s12_vld_reg),
        .radicand (s12_sd_reg),
        .sb_in    (sqb_in),
        .out_vld  (sqb_vld),
        .root     (nd_root),
        .sb_out   (sqb_out)
    );

    // ---------------------------------------------------------------
    // S13..S16: friction magnitude and scaled tangential products
    // ---------------------------------------------------------------
    logic               s13_vld_reg, s14_vld_reg, s15_vld_reg, s16_vld_reg;
    sqa_sb_t            s13_a_reg, s14_a_reg, s15_a_reg;
    sqb_sb_t            s13_b_reg, s14_b_reg, s15_b_reg;
    logic        [31:0] s13_nt_reg, s14_nt_reg, s15_nt_reg;
    logic        [49:0] s13_lp_reg;
    logic        [31:0] s14_mag_reg;
    logic signed [64:0] s15_px_reg, s15_py_reg;
    fda_sb_t            s16_a_reg;
    fdb_sb_t            s16_b_reg;
    logic        [63:0] s16_ax_reg, s16_ay_reg;
    logic        [31:0] s16_dvs_reg;

    logic        [49:0] s13_lp_next;
    logic        [33:0] lim;
    logic        [31:0] s14_mag_next;
    logic signed [64:0] s15_px_next, s15_py_next;
    logic signed [64:0] abs_x, abs_y;

    always_comb begin
        s13_lp_next  = 50'(fc_reg) * 50'(nd_root);
        lim          = s13_lp_reg[49:16];
        s14_mag_next = ({2'b00, s13_nt_reg} < lim) ? s13_nt_reg : lim[31:0];
        s15_px_next  = $signed({1'b0, s14_mag_reg}) * s14_a_reg.tan;
        s15_py_next  = $signed({1'b0, s14_mag_reg}) * s14_b_reg.tan;
        abs_x        = s15_px_reg[64] ? -s15_px_reg : s15_px_reg;
        abs_y        = s15_py_reg[64] ? -s15_py_reg : s15_py_reg;
    end

    // trunc(mag * vt / |vt|) for each component
    fda_sb_t     fda_out;
    fdb_sb_t     fdb_out;
    logic        fda_vld, fdb_vld;
    logic [31:0] fqx, fqy;

    pbcf_div #(
        .DVD_W (64),
        .DVS_W (32),
        .QUO_W (32),
        .SB_W  ($bits(fda_sb_t))
    ) u_fric_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s16_vld_reg),
        .dividend (s16_ax_reg),
        .divisor  (s16_dvs_reg),
        .sb_in    (s16_a_reg),
        .out_vld  (fda_vld),
        .quotient (fqx),
        .sb_out   (fda_out)
    );

    pbcf_div #(
        .DVD_W (64),
        .DVS_W (32),
        .QUO_W (32),
        .SB_W  ($bits(fdb_sb_t))
    ) u_fric_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s16_vld_reg),
        .dividend (s16_ay_reg),
        .divisor  (s16_dvs_reg),
        .sb_in    (s16_b_reg),
        .out_vld  (fdb_vld),
        .quotient (fqy),
        .sb_out   (fdb_out)
    );

    // ---------------------------------------------------------------
    // S17: apply friction, saturate, output register
    // ---------------------------------------------------------------
    logic signed [32:0] fx, fy;
    logic signed [63:0] rx, ry;
    out_item_t          m_data_next;

    always_comb begin
        fx = fda_out.neg ? -$signed({1'b0, fqx}) : $signed({1'b0, fqx});
        fy = fdb_out.neg ? -$signed({1'b0, fqy}) : $signed({1'b0, fqy});
        rx = 64'(fda_out.vc) - 64'(fx);
        ry = 64'(fdb_out.vc) - 64'(fy);
        m_data_next.new_vel_x   = fda_out.nt_nz ? sat32(rx) : fda_out.vc;
        m_data_next.new_vel_y   = fda_out.nt_nz ? sat32(ry) : fdb_out.vc;
        m_data_next.collided    = fdb_out.hit;
        m_data_next.node_id_out = fdb_out.node;
    end

    // ---------------------------------------------------------------
    // Valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
            s16_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= dt_vld_out;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= sqa_vld;
            s14_vld_reg <= s13_vld_reg;
            s15_vld_reg <= s14_vld_reg;
            s16_vld_reg <= s15_vld_reg;
            m_valid_reg <= fda_vld;
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg <= s_data;
            s1_dpx_reg  <= s1_dpx_next;
            s1_dpy_reg  <= s1_dpy_next;

            s2_item_reg <= s1_item_reg;
            s2_pdx_reg  <= s2_pdx_next;
            s2_pdy_reg  <= s2_pdy_next;
            s2_pvx_reg  <= s2_pvx_next;
            s2_pvy_reg  <= s2_pvy_next;

            s3_item_reg <= s2_item_reg;
            s3_d_reg    <= s3_d_next;
            s3_nv_reg   <= s3_nv_next;

            s4_item_reg <= dt_sb_out.item;
            s4_corr_reg <= s4_corr_next;
            s4_zero_reg <= s4_zero_next;
            s4_fix_reg  <= s4_fix_next;

            s5_item_reg <= s4_item_reg;
            s5_zero_reg <= s4_zero_reg;
            s5_fix_reg  <= s4_fix_reg;
            s5_pxh_reg  <= s5_pxh_next;
            s5_pxl_reg  <= s5_pxl_next;
            s5_pyh_reg  <= s5_pyh_next;
            s5_pyl_reg  <= s5_pyl_next;

            s6_item_reg <= s5_item_reg;
            s6_vcx_reg  <= s6_vcx_next;
            s6_vcy_reg  <= s6_vcy_next;
            s6_hit_reg  <= s5_fix_reg;

            s7_vcx_reg  <= s6_vcx_reg;
            s7_vcy_reg  <= s6_vcy_reg;
            s7_hit_reg  <= s6_hit_reg;
            s7_node_reg <= s6_item_reg.node_index;
            s7_mx_reg   <= s7_mx_next;
            s7_my_reg   <= s7_my_next;
            s7_dx_reg   <= tclamp(64'(dvx));
            s7_dy_reg   <= tclamp(64'(dvy));

            s8_vcx_reg  <= s7_vcx_reg;
            s8_vcy_reg  <= s7_vcy_reg;
            s8_hit_reg  <= s7_hit_reg;
            s8_node_reg <= s7_node_reg;
            s8_dx_reg   <= s7_dx_reg;
            s8_dy_reg   <= s7_dy_reg;
            s8_nq_reg   <= s8_sum_sh[34:0];

            s9_vcx_reg  <= s8_vcx_reg;
            s9_vcy_reg  <= s8_vcy_reg;
            s9_hit_reg  <= s8_hit_reg;
            s9_node_reg <= s8_node_reg;
            s9_dx_reg   <= s8_dx_reg;
            s9_dy_reg   <= s8_dy_reg;
            s9_qx_reg   <= s9_qx_next;
            s9_qy_reg   <= s9_qy_next;

            s10_vcx_reg  <= s9_vcx_reg;
            s10_vcy_reg  <= s9_vcy_reg;
            s10_hit_reg  <= s9_hit_reg;
            s10_node_reg <= s9_node_reg;
            s10_dx_reg   <= s9_dx_reg;
            s10_dy_reg   <= s9_dy_reg;
            s10_tx_reg   <= tclamp(64'(trx));
            s10_ty_reg   <= tclamp(64'(try_v));

            s11_vcx_reg  <= s10_vcx_reg;
            s11_vcy_reg  <= s10_vcy_reg;
            s11_hit_reg  <= s10_hit_reg;
            s11_node_reg <= s10_node_reg;
            s11_tx_reg   <= s10_tx_reg;
            s11_ty_reg   <= s10_ty_reg;
            s11_stx_reg  <= sq_tx[61:0];
            s11_sty_reg  <= sq_ty[61:0];
            s11_sdx_reg  <= sq_dx[61:0];
            s11_sdy_reg  <= sq_dy[61:0];

            s12_vcx_reg  <= s11_vcx_reg;
            s12_vcy_reg  <= s11_vcy_reg;
            s12_hit_reg  <= s11_hit_reg;
            s12_node_reg <= s11_node_reg;
            s12_tx_reg   <= s11_tx_reg;
            s12_ty_reg   <= s11_ty_reg;
            s12_st_reg   <= 64'(s11_stx_reg) + 64'(s11_sty_reg);
            s12_sd_reg   <= 64'(s11_sdx_reg) + 64'(s11_sdy_reg);

            s13_a_reg   <= sqa_out;
            s13_b_reg   <= sqb_out;
            s13_nt_reg  <= nt_root;
            s13_lp_reg  <= s13_lp_next;

            s14_a_reg   <= s13_a_reg;
            s14_b_reg   <= s13_b_reg;
            s14_nt_reg  <= s13_nt_reg;
            s14_mag_reg <= s14_mag_next;

            s15_a_reg   <= s14_a_reg;
            s15_b_reg   <= s14_b_reg;
            s15_nt_reg  <= s14_nt_reg;
            s15_px_reg  <= s15_px_next;
            s15_py_reg  <= s15_py_next;

            s16_a_reg.vc    <= s15_a_reg.vc;
            s16_a_reg.neg   <= s15_px_reg[64];
            s16_a_reg.nt_nz <= (s15_nt_reg != 32'd0);
            s16_b_reg.vc    <= s15_b_reg.vc;
            s16_b_reg.neg   <= s15_py_reg[64];
            s16_b_reg.hit   <= s15_a_reg.hit;
            s16_b_reg.node  <= s15_b_reg.node;
            s16_ax_reg      <= abs_x[63:0];
            s16_ay_reg      <= abs_y[63:0];
            s16_dvs_reg     <= (s15_nt_reg == 32'd0) ? 32'd1 : s15_nt_reg;

            m_data_reg <= m_data_next;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_sqrt_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        sqa_vld == sqb_vld)
        else $error("norm square-root units out of step");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        fda_vld == fdb_vld)
        else $error("friction dividers out of step");

    a_collided_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.collided) |->
            (kind_reg == BK_SEPARATE || kind_reg == BK_SLIP))
        else $error("collision flagged for a border kind without correction");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");

endmodule
